// ----- hw/rtl/uid_pkg.sv -----
// ----------------------------------------------------------------------------
// uid_pkg
// shared constants, payload types and command/status bundles for the
// deduplicating deque
// ----------------------------------------------------------------------------
package uid_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int VALUE_W    = 32;
	localparam int INDEX_W    = 4;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int SLOT_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int RK_W       = 3;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH = OP_W'(0);
	localparam logic [OP_W-1:0] OP_PEEK = OP_W'(1);
	localparam logic [OP_W-1:0] OP_POP  = OP_W'(2);

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_DUP  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_FULL = STATUS_W'(2);
	localparam logic [STATUS_W-1:0] ST_MISS = STATUS_W'(3);

	// result kinds chosen by the controller
	localparam logic [RK_W-1:0] RK_PUSH = RK_W'(0);
	localparam logic [RK_W-1:0] RK_DUP  = RK_W'(1);
	localparam logic [RK_W-1:0] RK_FULL = RK_W'(2);
	localparam logic [RK_W-1:0] RK_MISS = RK_W'(3);
	localparam logic [RK_W-1:0] RK_PEEK = RK_W'(4);
	localparam logic [RK_W-1:0] RK_POP  = RK_W'(5);

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [VALUE_W-1:0] value;
		logic [INDEX_W-1:0]        index;
	} req_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] data;
		logic [STATUS_W-1:0]       status;
		logic [CNT_W-1:0]          count;
	} rsp_word_t;

	typedef struct packed {
		logic            load;
		logic            rd_en;
		logic            rd_pop;
		logic            scan_clear;
		logic            scan_step;
		logic            res_load;
		logic [RK_W-1:0] res_kind;
	} uid_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            empty;
		logic            full;
		logic            idx_ok;
		logic            hit;
		logic            scan_done;
	} uid_stat_t;

	// circular slot arithmetic, both operands below DEPTH
	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return SLOT_W'(sum);
	endfunction

endpackage

// ----- hw/rtl/uid_dpath.sv -----
// ----------------------------------------------------------------------------
// uid_dpath
// entry memory, front/count registers, scan counter, compare and result word
// ----------------------------------------------------------------------------
module uid_dpath import uid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  req_word_t req,
	input  uid_cmd_t  cmd,
	output uid_stat_t stat,
	output rsp_word_t rsp
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [OP_W-1:0]       op_q;
	logic [INDEX_W-1:0]    idx_q;
	logic [SLOT_W-1:0]     front_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      scan_q;
	logic                  cmpv_q;
	rsp_word_t             rsp_q;

	logic [SLOT_W-1:0]   front_dec;
	logic [SLOT_W-1:0]   rd_addr;
	logic                scan_rd;
	logic                rd_fire;
	logic                push_commit;
	logic [CNT_W-1:0]    count_nxt;
	logic [VALUE_W-1:0]  data_nxt;
	logic [STATUS_W-1:0] status_nxt;

	assign front_dec   = (front_q == '0) ? SLOT_W'(DEPTH - 1) : front_q - 1'b1;
	assign scan_rd     = cmd.scan_step && (scan_q != count_q);
	assign rd_fire     = cmd.rd_en || scan_rd;
	assign push_commit = cmd.res_load && (cmd.res_kind == RK_PUSH);

	always_comb begin
		if (scan_rd) begin
			rd_addr = slot_add(front_q, scan_q);
		end else if (cmd.rd_pop) begin
			rd_addr = slot_add(front_q, count_q - 1'b1);
		end else begin
			rd_addr = slot_add(front_q, CNT_W'(idx_q));
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req.op;
			word_q <= DATA_WIDTH'(req.value);
			idx_q  <= req.index;
		end
	end

	always_ff @(posedge clk) begin
		if (push_commit) begin
			mem[front_dec] <= word_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_fire) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			cmpv_q <= 1'b0;
		end else if (cmd.scan_clear) begin
			scan_q <= '0;
			cmpv_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (scan_rd) begin
				scan_q <= scan_q + 1'b1;
			end
			cmpv_q <= scan_rd;
		end
	end

	always_comb begin
		unique case (cmd.res_kind)
			RK_PUSH: count_nxt = count_q + 1'b1;
			RK_POP:  count_nxt = count_q - 1'b1;
			default: count_nxt = count_q;
		endcase
	end

	always_comb begin
		unique case (cmd.res_kind)
			RK_PUSH: begin
				data_nxt   = '0;
				status_nxt = ST_OK;
			end
			RK_DUP: begin
				data_nxt   = '0;
				status_nxt = ST_DUP;
			end
			RK_FULL: begin
				data_nxt   = '0;
				status_nxt = ST_FULL;
			end
			RK_PEEK, RK_POP: begin
				data_nxt   = VALUE_W'(rd_data_q);
				status_nxt = ST_OK;
			end
			default: begin
				data_nxt   = '1;
				status_nxt = ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.res_load) begin
			count_q <= count_nxt;
			if (push_commit) begin
				front_q <= front_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rsp_q.data   <= data_nxt;
			rsp_q.status <= status_nxt;
			rsp_q.count  <= count_nxt;
		end
	end

	assign rsp = rsp_q;

	assign stat.op        = op_q;
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == CNT_W'(DEPTH));
	assign stat.idx_ok    = int'(idx_q) < int'(count_q);
	assign stat.hit       = cmpv_q && (rd_data_q == word_q);
	assign stat.scan_done = (scan_q == count_q) && !cmpv_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= DEPTH)
		else $error("entry count above depth");

	a_front_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(front_q) < DEPTH)
		else $error("front slot out of range");

	// the scan counter keeps its last value between pushes, so only check it while scanning
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> scan_q <= count_q)
		else $error("scan ran past the live entries");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push_commit |=> count_q == $past(count_q) + 1'b1)
		else $error("push commit did not grow the count");

endmodule

// ----- hw/rtl/uid_ctrl.sv -----
// ----------------------------------------------------------------------------
// uid_ctrl
// sequencer: dispatch by op, duplicate scan, result hand-off
// ----------------------------------------------------------------------------
module uid_ctrl import uid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  uid_stat_t stat,
	output uid_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ISSUE  = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0]      state_q;
	logic [1:0]      state_nxt;
	logic [RK_W-1:0] kind_q;
	logic [RK_W-1:0] kind_nxt;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		kind_nxt  = kind_q;
		cmd.res_kind = kind_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_ISSUE;
				end
			end
			S_ISSUE: begin
				state_nxt = S_FINISH;
				unique case (stat.op)
					OP_PUSH: begin
						if (stat.empty) begin
							kind_nxt = RK_PUSH;
						end else begin
							cmd.scan_clear = 1'b1;
							state_nxt      = S_SCAN;
						end
					end
					OP_PEEK: begin
						if (stat.idx_ok) begin
							cmd.rd_en = 1'b1;
							kind_nxt  = RK_PEEK;
						end else begin
							kind_nxt = RK_MISS;
						end
					end
					OP_POP: begin
						if (!stat.empty) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_pop = 1'b1;
							kind_nxt   = RK_POP;
						end else begin
							kind_nxt = RK_MISS;
						end
					end
					default: kind_nxt = RK_MISS;
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				// a match wins over fullness
				if (stat.hit) begin
					kind_nxt  = RK_DUP;
					state_nxt = S_FINISH;
				end else if (stat.scan_done) begin
					kind_nxt  = stat.full ? RK_FULL : RK_PUSH;
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= RK_MISS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			kind_q  <= kind_nxt;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> out_free)
		else $error("result word overwritten before taken");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rd_en, cmd.scan_clear, cmd.res_load}))
		else $error("conflicting datapath commands");

endmodule

// ----- hw/rtl/unique_insert_deque.sv -----
// ----------------------------------------------------------------------------
// unique_insert_deque
// bounded deque of signed words that refuses duplicates on push-front
// ----------------------------------------------------------------------------
//  channel  handshake              word        fields
//  req      req_valid/req_ready    req_word_t  op, value, index
//  rsp      rsp_valid/rsp_ready    rsp_word_t  data, status, count
//
//  peek, pop and a push into an empty deque pass the issue and finish states;
//  any other push also scans, one memory read per stored entry
//  one word in flight; req_ready returns the cycle after its result is loaded
//  a stalled rsp holds the result register and the sequencer waits behind it
//  reset clears front pointer and count; entry contents are never cleared
// ----------------------------------------------------------------------------
module unique_insert_deque import uid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	uid_cmd_t  cmd;
	uid_stat_t stat;

	uid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	uid_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
